[rtl/core/qco_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_pkg: shared types and constants for quadrilateral corner ordering
// Point format, arithmetic widths and the payloads passed between stages.
// ----------------------------------------------------------------------------
package qco_pkg;

  localparam int CoordW        = 20;
  localparam int CountW        = 8;
  localparam int CoordFracBits = 4;
  localparam int DiffW         = CoordW + 1;
  localparam int ProdW         = 2 * DiffW;
  localparam int CrossW        = ProdW + 1;
  localparam int AreaW         = CrossW + 1;
  localparam int NumPts        = 4;
  localparam int IdxW          = 2;

  localparam logic [CountW-1:0] QuadCount = CountW'(NumPts);
  // 1.0 in the product format
  localparam logic [AreaW-1:0]  AreaOne   = AreaW'(1) << (2 * CoordFracBits);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CrossW-1:0] cross_t;
  typedef logic [CrossW-1:0]        mag_t;
  typedef logic [AreaW-1:0]         area_t;
  typedef logic [IdxW-1:0]          idx_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    logic             cnt_ok;
    point_t [NumPts-1:0] p;
    point_t           tl;
    point_t           tr;
    point_t           br;
    point_t           bl;
  } sort_t;

  typedef struct packed {
    logic             cnt_ok;
    point_t [NumPts-1:0] p;
    point_t           tl;
    point_t           tr;
    point_t           br;
    point_t           bl;
    idx_t             smin;
    idx_t             smax;
    idx_t             dmin;
    idx_t             dmax;
    mag_t             mag0;
    mag_t             mag1;
  } geom_t;

  // order by y, then by x
  function automatic logic before_yx(point_t a, point_t b);
    logic r;
    if (a.y == b.y) begin
      r = a.x < b.x;
    end else begin
      r = a.y < b.y;
    end
    return r;
  endfunction

  function automatic diff_t sub_c(coord_t a, coord_t b);
    return diff_t'(a) - diff_t'(b);
  endfunction

  function automatic diff_t add_c(coord_t a, coord_t b);
    return diff_t'(a) + diff_t'(b);
  endfunction

endpackage
`default_nettype wire

[rtl/core/quad_corner_ordering_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quad_corner_ordering_core: orders four quadrilateral corners
// Input channel: point count and four signed Q16.4 corners per transfer.
// Output channel: top-left, top-right, bottom-right, bottom-left corners and
// a flag that marks the x+y / x-y fallback ordering.
//
// Each input transfer yields exactly one output transfer, in order. A count
// other than four gives an all-zero result. Corners are sorted by (y, x),
// split left/right by x, and replaced by the sum/difference extremes when
// the doubled areas of the two triangles add up to less than one square pixel.
//
// The pipeline holds two stages of sorting network, three of geometry (edge
// vectors, multipliers, cross products) and the output register. One item
// is taken per cycle while the receiver keeps taking results.
// Reset empties every stage. When the receiver stalls, each stage holds its
// item and the ready chain lets bubbles close up, so up to six items stay
// in flight before in_ready_o drops.
// ----------------------------------------------------------------------------
module quad_corner_ordering_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [qco_pkg::CountW-1:0]  point_count_i,
  input  wire logic signed [qco_pkg::CoordW-1:0] corner0_x_i,
  input  wire logic signed [qco_pkg::CoordW-1:0] corner0_y_i,
  input  wire logic signed [qco_pkg::CoordW-1:0] corner1_x_i,
  input  wire logic signed [qco_pkg::CoordW-1:0] corner1_y_i,
  input  wire logic signed [qco_pkg::CoordW-1:0] corner2_x_i,
  input  wire logic signed [qco_pkg::CoordW-1:0] corner2_y_i,
  input  wire logic signed [qco_pkg::CoordW-1:0] corner3_x_i,
  input  wire logic signed [qco_pkg::CoordW-1:0] corner3_y_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic signed [qco_pkg::CoordW-1:0] top_left_x_o,
  output logic signed [qco_pkg::CoordW-1:0] top_left_y_o,
  output logic signed [qco_pkg::CoordW-1:0] top_right_x_o,
  output logic signed [qco_pkg::CoordW-1:0] top_right_y_o,
  output logic signed [qco_pkg::CoordW-1:0] bottom_right_x_o,
  output logic signed [qco_pkg::CoordW-1:0] bottom_right_y_o,
  output logic signed [qco_pkg::CoordW-1:0] bottom_left_x_o,
  output logic signed [qco_pkg::CoordW-1:0] bottom_left_y_o,
  output logic                             used_fallback_o
);
  import qco_pkg::*;

  point_t [NumPts-1:0] pts;
  sort_t  sort_q;
  geom_t  geom_q;
  logic   sort_valid, sort_ready;
  logic   geom_valid, geom_ready;
  point_t tl, tr, br, bl;

  assign pts[0] = '{x: corner0_x_i, y: corner0_y_i};
  assign pts[1] = '{x: corner1_x_i, y: corner1_y_i};
  assign pts[2] = '{x: corner2_x_i, y: corner2_y_i};
  assign pts[3] = '{x: corner3_x_i, y: corner3_y_i};

  qco_sort u_sort (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_count_i  (point_count_i),
    .in_pts_i    (pts),
    .out_valid_o (sort_valid),
    .out_ready_i (sort_ready),
    .out_o       (sort_q)
  );

  qco_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sort_valid),
    .in_ready_o  (sort_ready),
    .in_i        (sort_q),
    .out_valid_o (geom_valid),
    .out_ready_i (geom_ready),
    .out_o       (geom_q)
  );

  qco_select u_select (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (geom_valid),
    .in_ready_o  (geom_ready),
    .in_i        (geom_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tl_o        (tl),
    .tr_o        (tr),
    .br_o        (br),
    .bl_o        (bl),
    .fb_o        (used_fallback_o)
  );

  assign top_left_x_o     = tl.x;
  assign top_left_y_o     = tl.y;
  assign top_right_x_o    = tr.x;
  assign top_right_y_o    = tr.y;
  assign bottom_right_x_o = br.x;
  assign bottom_right_y_o = br.y;
  assign bottom_left_x_o  = bl.x;
  assign bottom_left_y_o  = bl.y;

`ifndef SYNTH
  // an invalid count always comes out as an all-zero, non-fallback result
  a_bad_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom_valid && geom_ready && !geom_q.cnt_ok |=>
      !used_fallback_o && tl == '0 && tr == '0 && br == '0 && bl == '0)
    else $error("invalid count did not give a zero result");

  // split ordering keeps the upper pair above the lower pair and left of right
  a_split_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !used_fallback_o |->
      top_left_y_o <= bottom_left_y_o && top_right_y_o <= bottom_right_y_o &&
      top_left_x_o <= top_right_x_o && bottom_left_x_o <= bottom_right_x_o)
    else $error("split corners out of order");

  // fallback picks the x+y minimum as top-left and maximum as bottom-right, and the x-y minimum as bottom-left
  a_fallback_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && used_fallback_o |->
      $signed(add_c(tl.x, tl.y)) <= $signed(add_c(br.x, br.y)) &&
      $signed(sub_c(bl.x, bl.y)) <= $signed(sub_c(tr.x, tr.y)))
    else $error("fallback extremes out of order");
`endif

endmodule
`default_nettype wire

[rtl/core/qco_sort.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_sort: four-point sorting network and left/right split
// Stage 1 runs the first two compare levels, stage 2 the last level and
// splits the upper and lower pairs by x.
// ----------------------------------------------------------------------------
module qco_sort (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic [qco_pkg::CountW-1:0]            in_count_i,
  input  wire qco_pkg::point_t [qco_pkg::NumPts-1:0] in_pts_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output qco_pkg::sort_t                             out_o
);
  import qco_pkg::*;

  typedef struct packed {
    logic                cnt_ok;
    point_t [NumPts-1:0] b;
  } net_t;

  net_t   s1_d, s1_q;
  logic   s1_vld_q;
  sort_t  s2_d, s2_q;
  logic   s2_vld_q;
  logic   s1_ready, s2_ready;

  point_t a0, a1, a2, a3;
  point_t c1, c2;

  assign s2_ready   = !s2_vld_q || out_ready_i;
  assign s1_ready   = !s1_vld_q || s2_ready;
  assign in_ready_o = s1_ready;

  // compare levels (0,1)(2,3) then (0,2)(1,3)
  always_comb begin
    a0 = before_yx(in_pts_i[1], in_pts_i[0]) ? in_pts_i[1] : in_pts_i[0];
    a1 = before_yx(in_pts_i[1], in_pts_i[0]) ? in_pts_i[0] : in_pts_i[1];
    a2 = before_yx(in_pts_i[3], in_pts_i[2]) ? in_pts_i[3] : in_pts_i[2];
    a3 = before_yx(in_pts_i[3], in_pts_i[2]) ? in_pts_i[2] : in_pts_i[3];
    s1_d.cnt_ok = (in_count_i == QuadCount);
    s1_d.b[0]   = before_yx(a2, a0) ? a2 : a0;
    s1_d.b[2]   = before_yx(a2, a0) ? a0 : a2;
    s1_d.b[1]   = before_yx(a3, a1) ? a3 : a1;
    s1_d.b[3]   = before_yx(a3, a1) ? a1 : a3;
  end

  // last level (1,2), then split each pair by x; on equal x the earlier is left
  always_comb begin
    c1 = before_yx(s1_q.b[2], s1_q.b[1]) ? s1_q.b[2] : s1_q.b[1];
    c2 = before_yx(s1_q.b[2], s1_q.b[1]) ? s1_q.b[1] : s1_q.b[2];
    s2_d.cnt_ok = s1_q.cnt_ok;
    s2_d.p[0]   = s1_q.b[0];
    s2_d.p[1]   = c1;
    s2_d.p[2]   = c2;
    s2_d.p[3]   = s1_q.b[3];
    if (s1_q.b[0].x <= c1.x) begin
      s2_d.tl = s1_q.b[0];
      s2_d.tr = c1;
    end else begin
      s2_d.tl = c1;
      s2_d.tr = s1_q.b[0];
    end
    if (c2.x <= s1_q.b[3].x) begin
      s2_d.bl = c2;
      s2_d.br = s1_q.b[3];
    end else begin
      s2_d.bl = s1_q.b[3];
      s2_d.br = c2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_vld_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_vld_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_vld_q;
  assign out_o       = s2_q;

endmodule
`default_nettype wire

[rtl/core/qco_geom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_geom: triangle cross products and fallback extremes
// Stage 3 forms edge vectors and x+y / x-y, stage 4 the four products and
// the extreme indices, stage 5 the two cross products and their magnitudes.
// ----------------------------------------------------------------------------
module qco_geom (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire qco_pkg::sort_t in_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output qco_pkg::geom_t      out_o
);
  import qco_pkg::*;

  typedef struct packed {
    sort_t              pt;
    diff_t              ax;
    diff_t              ay;
    diff_t              bx;
    diff_t              by;
    diff_t              cx;
    diff_t              cy;
    diff_t [NumPts-1:0] s;
    diff_t [NumPts-1:0] d;
  } vec_t;

  typedef struct packed {
    sort_t pt;
    prod_t m0;
    prod_t m1;
    prod_t m2;
    prod_t m3;
    idx_t  smin;
    idx_t  smax;
    idx_t  dmin;
    idx_t  dmax;
  } prd_t;

  vec_t   s3_d, s3_q;
  prd_t   s4_d, s4_q;
  geom_t  s5_d, s5_q;
  logic   s3_vld_q, s4_vld_q, s5_vld_q;
  logic   s3_ready, s4_ready, s5_ready;
  cross_t x0, x1;

  assign s5_ready   = !s5_vld_q || out_ready_i;
  assign s4_ready   = !s4_vld_q || s5_ready;
  assign s3_ready   = !s3_vld_q || s4_ready;
  assign in_ready_o = s3_ready;

  always_comb begin
    s3_d.pt = in_i;
    s3_d.ax = sub_c(in_i.tr.x, in_i.tl.x);
    s3_d.ay = sub_c(in_i.tr.y, in_i.tl.y);
    s3_d.bx = sub_c(in_i.br.x, in_i.tl.x);
    s3_d.by = sub_c(in_i.br.y, in_i.tl.y);
    s3_d.cx = sub_c(in_i.bl.x, in_i.tl.x);
    s3_d.cy = sub_c(in_i.bl.y, in_i.tl.y);
    for (int i = 0; i < NumPts; i++) begin
      s3_d.s[i] = add_c(in_i.p[i].x, in_i.p[i].y);
      s3_d.d[i] = sub_c(in_i.p[i].x, in_i.p[i].y);
    end
  end

  // first minimum and last maximum in sorted order
  always_comb begin
    s4_d.pt   = s3_q.pt;
    s4_d.m0   = prod_t'(s3_q.ax) * prod_t'(s3_q.by);
    s4_d.m1   = prod_t'(s3_q.ay) * prod_t'(s3_q.bx);
    s4_d.m2   = prod_t'(s3_q.bx) * prod_t'(s3_q.cy);
    s4_d.m3   = prod_t'(s3_q.by) * prod_t'(s3_q.cx);
    s4_d.smin = '0;
    s4_d.smax = '0;
    s4_d.dmin = '0;
    s4_d.dmax = '0;
    for (int i = 1; i < NumPts; i++) begin
      if ($signed(s3_q.s[i]) < $signed(s3_q.s[s4_d.smin])) s4_d.smin = idx_t'(i);
      if ($signed(s3_q.s[i]) >= $signed(s3_q.s[s4_d.smax])) s4_d.smax = idx_t'(i);
      if ($signed(s3_q.d[i]) < $signed(s3_q.d[s4_d.dmin])) s4_d.dmin = idx_t'(i);
      if ($signed(s3_q.d[i]) >= $signed(s3_q.d[s4_d.dmax])) s4_d.dmax = idx_t'(i);
    end
  end

  always_comb begin
    x0 = cross_t'(s4_q.m0) - cross_t'(s4_q.m1);
    x1 = cross_t'(s4_q.m2) - cross_t'(s4_q.m3);
    s5_d.cnt_ok = s4_q.pt.cnt_ok;
    s5_d.p      = s4_q.pt.p;
    s5_d.tl     = s4_q.pt.tl;
    s5_d.tr     = s4_q.pt.tr;
    s5_d.br     = s4_q.pt.br;
    s5_d.bl     = s4_q.pt.bl;
    s5_d.smin   = s4_q.smin;
    s5_d.smax   = s4_q.smax;
    s5_d.dmin   = s4_q.dmin;
    s5_d.dmax   = s4_q.dmax;
    s5_d.mag0   = x0[CrossW-1] ? mag_t'(-x0) : mag_t'(x0);
    s5_d.mag1   = x1[CrossW-1] ? mag_t'(-x1) : mag_t'(x1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      if (s3_ready) begin
        s3_vld_q <= in_valid_i;
      end
      if (s4_ready) begin
        s4_vld_q <= s3_vld_q;
      end
      if (s5_ready) begin
        s5_vld_q <= s4_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && in_valid_i) begin
      s3_q <= s3_d;
    end
    if (s4_ready && s3_vld_q) begin
      s4_q <= s4_d;
    end
    if (s5_ready && s4_vld_q) begin
      s5_q <= s5_d;
    end
  end

  assign out_valid_o = s5_vld_q;
  assign out_o       = s5_q;

endmodule
`default_nettype wire

[rtl/core/qco_select.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qco_select: area test and final corner choice
// Sums the cross product magnitudes, picks the split or fallback corners,
// gives zeros for a bad count and holds the result in the output register.
// ----------------------------------------------------------------------------
module qco_select (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire qco_pkg::geom_t in_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output qco_pkg::point_t     tl_o,
  output qco_pkg::point_t     tr_o,
  output qco_pkg::point_t     br_o,
  output qco_pkg::point_t     bl_o,
  output logic                fb_o
);
  import qco_pkg::*;

  typedef struct packed {
    point_t tl;
    point_t tr;
    point_t br;
    point_t bl;
    logic   fb;
  } res_t;

  res_t  res_d, res_q;
  logic  vld_q;
  area_t area;
  logic  small_area;

  assign in_ready_o = !vld_q || out_ready_i;

  always_comb begin
    area       = area_t'(in_i.mag0) + area_t'(in_i.mag1);
    small_area = area < AreaOne;
    if (!in_i.cnt_ok) begin
      res_d = '0;
    end else if (small_area) begin
      res_d.tl = in_i.p[in_i.smin];
      res_d.br = in_i.p[in_i.smax];
      res_d.bl = in_i.p[in_i.dmin];
      res_d.tr = in_i.p[in_i.dmax];
      res_d.fb = 1'b1;
    end else begin
      res_d.tl = in_i.tl;
      res_d.tr = in_i.tr;
      res_d.br = in_i.br;
      res_d.bl = in_i.bl;
      res_d.fb = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q;
  assign tl_o        = res_q.tl;
  assign tr_o        = res_q.tr;
  assign br_o        = res_q.br;
  assign bl_o        = res_q.bl;
  assign fb_o        = res_q.fb;

endmodule
`default_nettype wire

[tb/quad_corner_ordering_checker.sv]
// ----------------------------------------------------------------------------
// quad_corner_ordering_checker: result checker for the corner ordering core
// Watches both channels. Each input transfer is turned into the expected
// corner order and kept in arrival order. Each output transfer is compared
// field by field against the oldest expected order.
// ----------------------------------------------------------------------------
module quad_corner_ordering_checker
  import qco_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [CountW-1:0] point_count_i,
  input  coord_t            corner0_x_i,
  input  coord_t            corner0_y_i,
  input  coord_t            corner1_x_i,
  input  coord_t            corner1_y_i,
  input  coord_t            corner2_x_i,
  input  coord_t            corner2_y_i,
  input  coord_t            corner3_x_i,
  input  coord_t            corner3_y_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  coord_t            top_left_x_i,
  input  coord_t            top_left_y_i,
  input  coord_t            top_right_x_i,
  input  coord_t            top_right_y_i,
  input  coord_t            bottom_right_x_i,
  input  coord_t            bottom_right_y_i,
  input  coord_t            bottom_left_x_i,
  input  coord_t            bottom_left_y_i,
  input  logic              used_fallback_i,
  output int                mismatches_o,
  output int                pending_o,
  output int                checked_o,
  output int                fallbacks_o
);

  typedef struct packed {
    coord_t tl_x;
    coord_t tl_y;
    coord_t tr_x;
    coord_t tr_y;
    coord_t br_x;
    coord_t br_y;
    coord_t bl_x;
    coord_t bl_y;
    logic   fallback;
  } corner_order_t;

  corner_order_t expected_orders_q[$];
  corner_order_t oldest_order;

  // cross product of (a - o) and (b - o), twice the triangle area
  function automatic longint twice_area(longint ox, longint oy, longint ax, longint ay,
                                        longint bx, longint by);
    return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
  endfunction

  function automatic corner_order_t order_corners(
    logic [CountW-1:0] cnt,
    coord_t x0, coord_t y0, coord_t x1, coord_t y1,
    coord_t x2, coord_t y2, coord_t x3, coord_t y3
  );
    longint        px[4];
    longint        py[4];
    longint        tx, ty, cr0, cr1, area, s, d;
    int            i, j, itl, itr, ibr, ibl, smin, smax, dmin, dmax;
    corner_order_t r;
    r = '0;
    if (cnt != QuadCount) begin
      return r;
    end
    px[0] = x0; py[0] = y0;
    px[1] = x1; py[1] = y1;
    px[2] = x2; py[2] = y2;
    px[3] = x3; py[3] = y3;

    // insertion sort by y, then x
    for (i = 1; i < 4; i++) begin
      tx = px[i];
      ty = py[i];
      j  = i - 1;
      while (j >= 0 && (ty < py[j] || (ty == py[j] && tx < px[j]))) begin
        px[j+1] = px[j];
        py[j+1] = py[j];
        j--;
      end
      px[j+1] = tx;
      py[j+1] = ty;
    end

    // equal x keeps the earlier point on the left
    if (px[0] <= px[1]) begin
      itl = 0; itr = 1;
    end else begin
      itl = 1; itr = 0;
    end
    if (px[2] <= px[3]) begin
      ibl = 2; ibr = 3;
    end else begin
      ibl = 3; ibr = 2;
    end

    cr0  = twice_area(px[itl], py[itl], px[itr], py[itr], px[ibr], py[ibr]);
    cr1  = twice_area(px[itl], py[itl], px[ibr], py[ibr], px[ibl], py[ibl]);
    area = (cr0 < 0 ? -cr0 : cr0) + (cr1 < 0 ? -cr1 : cr1);

    if (area < (longint'(1) << (2 * CoordFracBits))) begin
      smin = 0; smax = 0; dmin = 0; dmax = 0;
      for (i = 1; i < 4; i++) begin
        s = px[i] + py[i];
        d = px[i] - py[i];
        if (s <  px[smin] + py[smin]) smin = i;
        if (s >= px[smax] + py[smax]) smax = i;
        if (d <  px[dmin] - py[dmin]) dmin = i;
        if (d >= px[dmax] - py[dmax]) dmax = i;
      end
      itl = smin;
      ibr = smax;
      ibl = dmin;
      itr = dmax;
      r.fallback = 1'b1;
    end

    r.tl_x = coord_t'(px[itl]);
    r.tl_y = coord_t'(py[itl]);
    r.tr_x = coord_t'(px[itr]);
    r.tr_y = coord_t'(py[itr]);
    r.br_x = coord_t'(px[ibr]);
    r.br_y = coord_t'(py[ibr]);
    r.bl_x = coord_t'(px[ibl]);
    r.bl_y = coord_t'(py[ibl]);
    return r;
  endfunction

  task automatic check_coord(input string name, input coord_t want, input coord_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_orders_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_orders_q.push_back(order_corners(point_count_i,
          corner0_x_i, corner0_y_i, corner1_x_i, corner1_y_i,
          corner2_x_i, corner2_y_i, corner3_x_i, corner3_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_orders_q.size() == 0) begin
          $error("result transfer with no expected order waiting");
          mismatches_o++;
        end else begin
          oldest_order = expected_orders_q.pop_front();
          check_coord("top_left_x",     oldest_order.tl_x, top_left_x_i);
          check_coord("top_left_y",     oldest_order.tl_y, top_left_y_i);
          check_coord("top_right_x",    oldest_order.tr_x, top_right_x_i);
          check_coord("top_right_y",    oldest_order.tr_y, top_right_y_i);
          check_coord("bottom_right_x", oldest_order.br_x, bottom_right_x_i);
          check_coord("bottom_right_y", oldest_order.br_y, bottom_right_y_i);
          check_coord("bottom_left_x",  oldest_order.bl_x, bottom_left_x_i);
          check_coord("bottom_left_y",  oldest_order.bl_y, bottom_left_y_i);
          if (used_fallback_i !== oldest_order.fallback) begin
            $error("used_fallback: expected %0b, got %0b", oldest_order.fallback,
                   used_fallback_i);
            mismatches_o++;
          end
          checked_o++;
          if (oldest_order.fallback) fallbacks_o++;
        end
      end
      pending_o <= expected_orders_q.size();
    end
  end

endmodule

[tb/tb_quad_corner_ordering_core.sv]
// ----------------------------------------------------------------------------
// tb_quad_corner_ordering_core: testbench for the corner ordering core
// Sends directed quads (bad counts, coordinate extremes, ties, the area
// threshold, collinear and equal-sum points) and then random quads shaped
// to hit both the normal split and the fallback ordering. Both channels
// idle at random; the receiver holds off long once so the core fills up.
// ----------------------------------------------------------------------------
module tb_quad_corner_ordering_core;
  import qco_pkg::*;

  localparam int NumRandom  = 750;
  localparam int CycleLimit = 300000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CountW-1:0] point_count;
  coord_t            corner0_x, corner0_y, corner1_x, corner1_y;
  coord_t            corner2_x, corner2_y, corner3_x, corner3_y;
  logic              out_valid;
  logic              out_ready;
  coord_t            top_left_x, top_left_y, top_right_x, top_right_y;
  coord_t            bottom_right_x, bottom_right_y, bottom_left_x, bottom_left_y;
  logic              used_fallback;

  int mismatches, pending, checked, fallbacks;
  int cycle_count;
  int quads_sent;
  int bad_counts;
  bit send_burst;
  bit recv_burst;
  int qx[4];
  int qy[4];

  quad_corner_ordering_core dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .point_count_i    (point_count),
    .corner0_x_i      (corner0_x),
    .corner0_y_i      (corner0_y),
    .corner1_x_i      (corner1_x),
    .corner1_y_i      (corner1_y),
    .corner2_x_i      (corner2_x),
    .corner2_y_i      (corner2_y),
    .corner3_x_i      (corner3_x),
    .corner3_y_i      (corner3_y),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .top_left_x_o     (top_left_x),
    .top_left_y_o     (top_left_y),
    .top_right_x_o    (top_right_x),
    .top_right_y_o    (top_right_y),
    .bottom_right_x_o (bottom_right_x),
    .bottom_right_y_o (bottom_right_y),
    .bottom_left_x_o  (bottom_left_x),
    .bottom_left_y_o  (bottom_left_y),
    .used_fallback_o  (used_fallback)
  );

  quad_corner_ordering_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .point_count_i    (point_count),
    .corner0_x_i      (corner0_x),
    .corner0_y_i      (corner0_y),
    .corner1_x_i      (corner1_x),
    .corner1_y_i      (corner1_y),
    .corner2_x_i      (corner2_x),
    .corner2_y_i      (corner2_y),
    .corner3_x_i      (corner3_x),
    .corner3_y_i      (corner3_y),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .top_left_x_i     (top_left_x),
    .top_left_y_i     (top_left_y),
    .top_right_x_i    (top_right_x),
    .top_right_y_i    (top_right_y),
    .bottom_right_x_i (bottom_right_x),
    .bottom_right_y_i (bottom_right_y),
    .bottom_left_x_i  (bottom_left_x),
    .bottom_left_y_i  (bottom_left_y),
    .used_fallback_i  (used_fallback),
    .mismatches_o     (mismatches),
    .pending_o        (pending),
    .checked_o        (checked),
    .fallbacks_o      (fallbacks)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly short, now and then long
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 1048575)) - 524288;
  endfunction

  // offer one quad, hold it until the transfer, then maybe idle
  task automatic send_quad(input int cnt, input int x0, input int y0, input int x1,
                           input int y1, input int x2, input int y2, input int x3,
                           input int y3);
    int gap;
    in_valid    <= 1'b1;
    point_count <= CountW'(cnt);
    corner0_x   <= coord_t'(x0);
    corner0_y   <= coord_t'(y0);
    corner1_x   <= coord_t'(x1);
    corner1_y   <= coord_t'(y1);
    corner2_x   <= coord_t'(x2);
    corner2_y   <= coord_t'(y2);
    corner3_x   <= coord_t'(x3);
    corner3_y   <= coord_t'(y3);
    do @(posedge clk); while (!in_ready);
    quads_sent++;
    if (CountW'(cnt) != QuadCount) bad_counts++;
    if (!send_burst) begin
      gap = pick_len();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random_quad();
    int kind, cnt, bx, by, dx, dy, w, h, i, k, t;
    kind = $urandom_range(0, 19);
    cnt  = QuadCount;
    bx   = rand_coord();
    by   = rand_coord();
    for (i = 0; i < 4; i++) begin
      qx[i] = rand_coord();
      qy[i] = rand_coord();
    end
    case (kind)
      0, 1, 2, 3: begin
        // full-range corners as drawn
      end
      4, 5: begin
        // tiny cluster: many ties, area mostly under one
        for (i = 0; i < 4; i++) begin
          qx[i] = bx + $urandom_range(0, 3);
          qy[i] = by + $urandom_range(0, 3);
        end
      end
      6, 7: begin
        // around the area threshold
        for (i = 0; i < 4; i++) begin
          qx[i] = bx + $urandom_range(0, 20);
          qy[i] = by + $urandom_range(0, 20);
        end
      end
      8: begin
        dx = int'($urandom_range(0, 80)) - 40;
        dy = int'($urandom_range(0, 80)) - 40;
        for (i = 0; i < 4; i++) begin
          k     = $urandom_range(0, 7);
          qx[i] = bx + k * dx;
          qy[i] = by + k * dy;
        end
      end
      9, 10: begin
        w = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 24) : $urandom_range(0, 4000);
        h = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 24) : $urandom_range(0, 4000);
        qx[0] = bx;     qy[0] = by;
        qx[1] = bx + w; qy[1] = by;
        qx[2] = bx + w; qy[2] = by + h;
        qx[3] = bx;     qy[3] = by + h;
      end
      11: begin
        // duplicated corners
        k = $urandom_range(1, 3);
        for (i = 0; i < k; i++) begin
          t = $urandom_range(0, 3);
          qx[$urandom_range(0, 3)] = qx[t];
          qy[$urandom_range(0, 3)] = qy[t];
        end
      end
      12, 13, 14: begin
        for (i = 0; i < 4; i++) begin
          qx[i] = bx + $urandom_range(0, 2000);
          qy[i] = by + $urandom_range(0, 2000);
        end
      end
      15: begin
        // equal x+y or equal x-y along a line
        dy = ($urandom_range(0, 1) != 0) ? -1 : 1;
        for (i = 0; i < 4; i++) begin
          t     = $urandom_range(0, 30);
          qx[i] = bx + t;
          qy[i] = by + dy * t;
        end
      end
      default: begin
        if ($urandom_range(0, 1) != 0) cnt = $urandom_range(0, 255);
        else cnt = QuadCount ^ (1 << $urandom_range(0, CountW - 1));
      end
    endcase
    for (i = 3; i > 0; i--) begin
      k = $urandom_range(0, i);
      t = qx[i]; qx[i] = qx[k]; qx[k] = t;
      t = qy[i]; qy[i] = qy[k]; qy[k] = t;
    end
    send_quad(cnt, qx[0], qy[0], qx[1], qy[1], qx[2], qy[2], qx[3], qy[3]);
  endtask

  // stimulus and verdict
  initial begin
    in_valid    = 1'b0;
    point_count = '0;
    corner0_x = '0; corner0_y = '0; corner1_x = '0; corner1_y = '0;
    corner2_x = '0; corner2_y = '0; corner3_x = '0; corner3_y = '0;
    send_burst = 1'b0;
    wait (rst_n);
    @(posedge clk);

    // counts other than four give zeros
    send_quad(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_quad(255, 524287, 524287, 524287, 524287, 524287, 524287, 524287, 524287);
    send_quad(3, -5, 7, 100, -3, 12, 12, 40, 80);
    send_quad(5, 10, 20, 30, 40, 50, 60, 70, 80);
    send_quad(132, 0, 0, 160, 0, 160, 160, 0, 160);
    // all corners at one point
    send_quad(4, 0, 0, 0, 0, 0, 0, 0, 0);
    send_quad(4, 524287, 524287, 524287, 524287, 524287, 524287, 524287, 524287);
    send_quad(4, -524288, -524288, -524288, -524288, -524288, -524288, -524288, -524288);
    // coordinate extremes, largest area
    send_quad(4, 524287, 524287, -524288, -524288, 524287, -524288, -524288, 524287);
    send_quad(4, -524288, 524287, 524287, -524288, -524288, -524288, 524287, 524287);
    // plain square in several orders
    send_quad(4, 0, 0, 160, 0, 160, 160, 0, 160);
    send_quad(4, 160, 160, 0, 160, 0, 0, 160, 0);
    send_quad(4, 0, 160, 160, 0, 160, 160, 0, 0);
    // area exactly one, then just under
    send_quad(4, 0, 0, 8, 0, 8, 16, 0, 16);
    send_quad(4, 8, 15, 0, 0, 0, 15, 8, 0);
    // equal x within the top and bottom pairs
    send_quad(4, 5, 0, 5, 10, 100, 200, 100, 300);
    // two pairs of identical points
    send_quad(4, 30, 30, -30, -30, 30, 30, -30, -30);
    // collinear on x+y = 10 and on x-y = 0: fallback with tied extremes
    send_quad(4, 0, 10, 5, 5, 10, 0, 3, 7);
    send_quad(4, -8, -8, 4, 4, 0, 0, 4, 4);
    // skewed quad with ties in y
    send_quad(4, -200, 50, 300, 50, -400, -70, 90, -70);

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 60 == 0) send_burst = ($urandom_range(0, 3) == 0);
      send_random_quad();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d quads, %0d with a count other than four.", quads_sent, bad_counts);
    $display("Checked %0d ordered results, %0d of them from the fallback ordering.",
             checked, fallbacks);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result side: hold off long once so the core fills and drops in_ready
  initial begin
    int run;
    int stall;
    out_ready  = 1'b0;
    recv_burst = 1'b0;
    wait (rst_n);
    repeat (120) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run = pick_len();
      repeat (run + 1) @(posedge clk);
      if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
      if (!recv_burst) begin
        stall = pick_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

endmodule

[filelist.f]
rtl/core/qco_pkg.sv
rtl/core/qco_sort.sv
rtl/core/qco_geom.sv
rtl/core/qco_select.sv
rtl/core/quad_corner_ordering_core.sv
tb/quad_corner_ordering_checker.sv
tb/tb_quad_corner_ordering_core.sv
